FILE: src/crc16_frame_generate_check_unit_macros.svh
// ----------------------------------------------------------------------------
// crc16 frame unit assertion macros
// concurrent assertion wrappers, empty in synthesis builds
// ----------------------------------------------------------------------------
`ifndef CRC16_FRAME_GENERATE_CHECK_UNIT_MACROS_SVH
`define CRC16_FRAME_GENERATE_CHECK_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CRCU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define CRCU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CRCU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define CRCU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: src/crc16fgc_pkg.sv
// ----------------------------------------------------------------------------
// crc16 frame unit package
// shared codes, command format and the byte-wide crc update
// ----------------------------------------------------------------------------
package crc16fgc_pkg;

    localparam int unsigned MAX_FRAME_DEFAULT = 1024;
    localparam int unsigned LEN_W             = 11;
    localparam logic [LEN_W-1:0] EXP_LEN_RESET = 11'd9;
    localparam logic [15:0] CRC_POLY          = 16'h8408;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam int unsigned QUEUE_DEPTH       = 4;
    localparam int unsigned QUEUE_AW          = 2;

    // result kind carried on the output tuser
    typedef enum logic [1:0] {
        VERDICT_DATA    = 2'd0,
        VERDICT_OK      = 2'd1,
        VERDICT_CRC_ERR = 2'd2,
        VERDICT_LEN_ERR = 2'd3
    } t_verdict;

    // what follows the optional data byte of a command
    typedef enum logic [1:0] {
        TAIL_NONE    = 2'd0,
        TAIL_CRC     = 2'd1,
        TAIL_VERDICT = 2'd2
    } t_tail;

    // one queued command: up to three result transfers
    typedef struct packed {
        logic        emit_byte;
        logic [7:0]  data;
        t_tail       tail;
        logic [15:0] crc;
        t_verdict    verdict;
    } t_cmd;

    // queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // reflected crc update, one byte, lsb first
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: src/crc16fgc_front.sv
// ----------------------------------------------------------------------------
// crc16 frame unit front end
// accepts bytes, tracks frame state and crc, emits commands to the queue
// ----------------------------------------------------------------------------
module crc16fgc_front #(
    parameter int unsigned MAX_FRAME = crc16fgc_pkg::MAX_FRAME_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wen,
    input  logic [crc16fgc_pkg::LEN_W-1:0]      i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_func,
    input  logic [7:0]                          i_byte,
    input  logic                                i_last,
    input  crc16fgc_pkg::t_q_stat               i_q_stat,
    output logic                                o_push,
    output crc16fgc_pkg::t_cmd                  o_cmd
);
    import crc16fgc_pkg::*;

    localparam int unsigned CW = $clog2(MAX_FRAME + 2);
    localparam int unsigned LW = (CW > LEN_W) ? CW : LEN_W;

    logic [LEN_W-1:0] r_exp_len;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_held0, n_held0;
    logic [7:0]       r_held1, n_held1;
    logic [1:0]       r_held_cnt, n_held_cnt;
    logic [CW-1:0]    r_count, n_count;
    logic             r_mode;

    logic mode;
    logic accept;
    logic release_old;
    logic len_ok;
    logic crc_match;
    logic [15:0] crc_inv;

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;
    assign mode    = (r_count == '0) ? i_func : r_mode;

    // frame byte count, saturating one past the maximum
    always_comb begin
        if (r_count < CW'(MAX_FRAME + 1)) begin
            n_count = r_count + 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    // crc and holding pair update
    always_comb begin
        release_old = 1'b0;
        n_held0     = r_held0;
        n_held1     = r_held1;
        n_held_cnt  = r_held_cnt;
        if (!mode) begin
            n_crc = crc_fold(r_crc, i_byte);
        end else begin
            release_old = (r_held_cnt == 2'd2);
            if (release_old) begin
                n_crc      = crc_fold(r_crc, r_held0);
                n_held0    = r_held1;
                n_held1    = i_byte;
                n_held_cnt = 2'd2;
            end else begin
                n_crc = r_crc;
                if (r_held_cnt[0]) begin
                    n_held1 = i_byte;
                end else begin
                    n_held0 = i_byte;
                end
                n_held_cnt = r_held_cnt + 2'd1;
            end
        end
    end

    // end of frame checks
    assign crc_inv   = ~n_crc;
    assign len_ok    = (n_count >= CW'(2)) && (n_count <= CW'(MAX_FRAME)) &&
                       (LW'(n_count) == LW'(r_exp_len)) && (n_held_cnt == 2'd2);
    assign crc_match = (n_held0 == crc_inv[7:0]) && (n_held1 == crc_inv[15:8]);

    // command build
    always_comb begin
        o_cmd.crc = crc_inv;
        if (!mode) begin
            o_cmd.emit_byte = 1'b1;
            o_cmd.data      = i_byte;
            o_cmd.tail      = i_last ? TAIL_CRC : TAIL_NONE;
            o_cmd.verdict   = VERDICT_DATA;
        end else begin
            o_cmd.emit_byte = release_old;
            o_cmd.data      = r_held0;
            o_cmd.tail      = i_last ? TAIL_VERDICT : TAIL_NONE;
            if (!len_ok) begin
                o_cmd.verdict = VERDICT_LEN_ERR;
            end else if (crc_match) begin
                o_cmd.verdict = VERDICT_OK;
            end else begin
                o_cmd.verdict = VERDICT_CRC_ERR;
            end
        end
    end

    assign o_push = accept && (o_cmd.emit_byte || (o_cmd.tail != TAIL_NONE));

    // frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_len  <= EXP_LEN_RESET;
            r_crc      <= CRC_INIT;
            r_held0    <= '0;
            r_held1    <= '0;
            r_held_cnt <= '0;
            r_count    <= '0;
            r_mode     <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_exp_len <= i_cfg_wdata;
            end
            if (accept) begin
                if (i_last) begin
                    r_crc      <= CRC_INIT;
                    r_held0    <= '0;
                    r_held1    <= '0;
                    r_held_cnt <= '0;
                    r_count    <= '0;
                    r_mode     <= 1'b0;
                end else begin
                    r_crc      <= n_crc;
                    r_held0    <= n_held0;
                    r_held1    <= n_held1;
                    r_held_cnt <= n_held_cnt;
                    r_count    <= n_count;
                    r_mode     <= mode;
                end
            end
        end
    end

endmodule

FILE: src/crc16fgc_queue.sv
// ----------------------------------------------------------------------------
// crc16 frame unit command queue
// short register fifo between front end and back end
// ----------------------------------------------------------------------------
module crc16fgc_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  crc16fgc_pkg::t_cmd    i_cmd,
    input  logic                  i_pop,
    output crc16fgc_pkg::t_cmd    o_head,
    output crc16fgc_pkg::t_q_stat o_stat
);
    import crc16fgc_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr;
    logic [QUEUE_AW-1:0] r_rptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_stat.full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_mem[r_rptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: src/crc16fgc_back.sv
// ----------------------------------------------------------------------------
// crc16 frame unit back end
// expands queued commands into result transfers through an output register
// ----------------------------------------------------------------------------
module crc16fgc_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  crc16fgc_pkg::t_cmd    i_head,
    input  crc16fgc_pkg::t_q_stat i_q_stat,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_byte,
    output logic [1:0]            o_verdict,
    output logic                  o_frame_end
);
    import crc16fgc_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    t_verdict   r_verdict;
    logic       r_frame_end;
    logic [1:0] r_step;

    logic       load;
    logic       entry_done;
    logic [1:0] tail_step;
    logic [7:0] n_byte;
    t_verdict   n_verdict;
    logic       n_frame_end;

    assign load      = !i_q_stat.empty && (!r_valid || i_ready);
    assign o_pop     = load && entry_done;
    assign tail_step = r_step - {1'b0, i_head.emit_byte};

    // pick the result for the current step of the head command
    always_comb begin
        n_byte      = i_head.data;
        n_verdict   = VERDICT_DATA;
        n_frame_end = 1'b0;
        entry_done  = 1'b1;
        if (i_head.emit_byte && (r_step == 2'd0)) begin
            entry_done = (i_head.tail == TAIL_NONE);
        end else begin
            case (i_head.tail)
                TAIL_CRC: begin
                    if (tail_step == 2'd0) begin
                        n_byte     = i_head.crc[7:0];
                        entry_done = 1'b0;
                    end else begin
                        n_byte      = i_head.crc[15:8];
                        n_frame_end = 1'b1;
                    end
                end
                TAIL_VERDICT: begin
                    n_byte      = 8'h00;
                    n_verdict   = i_head.verdict;
                    n_frame_end = 1'b1;
                end
                default: begin
                    entry_done = 1'b1;
                end
            endcase
        end
    end

    // output register and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_step  <= entry_done ? 2'd0 : r_step + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte      <= n_byte;
            r_verdict   <= n_verdict;
            r_frame_end <= n_frame_end;
        end
    end

    assign o_valid     = r_valid;
    assign o_byte      = r_byte;
    assign o_verdict   = r_verdict;
    assign o_frame_end = r_frame_end;

endmodule

FILE: src/crc16_frame_generate_check_unit.sv
// ----------------------------------------------------------------------------
// crc16 frame generate / check unit
// Takes one byte per cycle on the input stream. In generate mode (tuser 0 on
// the first byte) each byte is passed on and the frame's last byte is
// followed by the inverted reflected CRC-16 (poly 0x8408, preset 0xFFFF),
// low byte first, the second CRC byte carrying tlast. In check mode the last
// two bytes are held back and one verdict transfer (tuser: 1 ok, 2 crc error,
// 3 length error, tdata 0, tlast 1) ends the frame; the length must equal the
// expected length register. Input bytes are taken every cycle while the
// four-entry command queue has room; results leave one per cycle from the
// output register, so a generate frame of N bytes gives N+2 result transfers,
// and the output port sets the sustained rate. Each result passes through
// the command queue entry and then the output register.
// ----------------------------------------------------------------------------
`include "crc16_frame_generate_check_unit_macros.svh"

module crc16_frame_generate_check_unit #(
    parameter int unsigned MAX_FRAME = crc16fgc_pkg::MAX_FRAME_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // expected frame length register
    input  logic                            i_cfg_wen,
    input  logic [crc16fgc_pkg::LEN_W-1:0]  i_cfg_wdata,
    // input byte stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
    input  logic [0:0]                      s_axis_tuser,  // [0] func
    input  logic                            s_axis_tlast,
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,  // [7:0] out_byte
    output logic [1:0]                      m_axis_tuser,  // [1:0] verdict
    output logic                            m_axis_tlast
);
    import crc16fgc_pkg::*;

    logic    push;
    logic    pop;
    t_cmd    push_cmd;
    t_cmd    head_cmd;
    t_q_stat q_stat;

    // byte intake and frame tracking
    crc16fgc_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_func      (s_axis_tuser[0]),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    // command queue
    crc16fgc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_stat  (q_stat)
    );

    // result expansion
    crc16fgc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_cmd),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_byte      (m_axis_tdata),
        .o_verdict   (m_axis_tuser),
        .o_frame_end (m_axis_tlast)
    );

    // checks
    `CRCU_ASSERT_IMP(a_verdict_ends_frame, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser != VERDICT_DATA), m_axis_tlast && (m_axis_tdata == 8'h00), "verdict transfer without frame end or with nonzero byte")
    `CRCU_ASSERT_IMP(a_queue_status, i_clk, i_rst_n, 1'b1, !(q_stat.full && q_stat.empty), "queue flagged full and empty together")
    `CRCU_ASSERT_NXT(a_no_result_from_nothing, i_clk, i_rst_n, q_stat.empty && !m_axis_tvalid, !m_axis_tvalid, "result appeared with empty queue")

endmodule

FILE: tb/crc_frame_scoreboard.sv
// ----------------------------------------------------------------------------
// crc16 frame unit scoreboard
// Tracks the frame state of the unit (running crc, held trailer bytes, byte
// count, latched mode, expected length) and queues the result transfers that
// each accepted input byte causes. Output transfers are compared field by
// field against the oldest queued result.
// ----------------------------------------------------------------------------
package crc_frame_tb_pkg;

    import crc16fgc_pkg::*;

    // short maximum frame so the length limit and saturation are reached quickly
    localparam int unsigned FRAME_LIMIT = 16;

    // one output transfer as the unit should produce it
    typedef struct packed {
        logic [7:0] out_byte;
        t_verdict   verdict;
        logic       frame_end;
    } t_frame_result;

    class crc_frame_scoreboard;

        logic [LEN_W-1:0] exp_len = EXP_LEN_RESET;
        logic [15:0]      fcs_acc;
        logic [7:0]       held [2];
        int unsigned      held_cnt;
        logic [LEN_W-1:0] byte_cnt;
        logic             frame_func;
        t_frame_result    predicted_out [$];
        int unsigned      mismatches = 0;
        int unsigned      results_checked = 0;
        int unsigned      gen_frames = 0;
        int unsigned      chk_frames = 0;
        int unsigned      verdict_hits [4];

        function new();
            foreach (verdict_hits[i]) verdict_hits[i] = 0;
            clear_frame();
        endfunction

        // reflected crc-16, one data bit per step, lsb first
        static function logic [15:0] fold_byte(logic [15:0] acc, logic [7:0] b);
            logic fb;
            for (int i = 0; i < 8; i++) begin
                fb  = acc[0] ^ b[i];
                acc = acc >> 1;
                if (fb) begin
                    acc = acc ^ CRC_POLY;
                end
            end
            return acc;
        endfunction

        function void clear_frame();
            fcs_acc    = CRC_INIT;
            held[0]    = 8'h00;
            held[1]    = 8'h00;
            held_cnt   = 0;
            byte_cnt   = '0;
            frame_func = 1'b0;
        endfunction

        function void push_result(logic [7:0] b, t_verdict v, logic e);
            t_frame_result r;
            r.out_byte  = b;
            r.verdict   = v;
            r.frame_end = e;
            predicted_out.push_back(r);
        endfunction

        function int unsigned pending();
            return predicted_out.size();
        endfunction

        // one accepted input byte
        function void note_byte(logic func, logic [7:0] b, logic last);
            logic [15:0] fcs;
            t_verdict    v;
            // mode is latched on the first byte of a frame
            if (byte_cnt == 0) begin
                frame_func = func;
            end
            if (byte_cnt < FRAME_LIMIT + 1) begin
                byte_cnt = byte_cnt + 1'b1;
            end
            if (frame_func == 1'b0) begin
                // generate: pass through, append inverted crc low then high
                fcs_acc = fold_byte(fcs_acc, b);
                push_result(b, VERDICT_DATA, 1'b0);
                if (last) begin
                    fcs = ~fcs_acc;
                    push_result(fcs[7:0], VERDICT_DATA, 1'b0);
                    push_result(fcs[15:8], VERDICT_DATA, 1'b1);
                    gen_frames++;
                    clear_frame();
                end
            end else begin
                // check: two newest bytes stay held, older one is released
                if (held_cnt == 2) begin
                    fcs_acc = fold_byte(fcs_acc, held[0]);
                    push_result(held[0], VERDICT_DATA, 1'b0);
                    held[0] = held[1];
                    held[1] = b;
                end else begin
                    held[held_cnt] = b;
                    held_cnt++;
                end
                if (last) begin
                    fcs = ~fcs_acc;
                    // length is judged before the crc
                    if (byte_cnt < 2 || byte_cnt > FRAME_LIMIT || byte_cnt != exp_len ||
                        held_cnt != 2) begin
                        v = VERDICT_LEN_ERR;
                    end else if (held[0] == fcs[7:0] && held[1] == fcs[15:8]) begin
                        v = VERDICT_OK;
                    end else begin
                        v = VERDICT_CRC_ERR;
                    end
                    push_result(8'h00, v, 1'b1);
                    verdict_hits[int'(v)]++;
                    chk_frames++;
                    clear_frame();
                end
            end
        endfunction

        // one accepted output transfer
        function void check_result(logic [7:0] b, t_verdict v, logic e);
            t_frame_result want;
            if (predicted_out.size() == 0) begin
                $error("unexpected result transfer: out_byte %h verdict %0d frame_end %b",
                       b, v, e);
                mismatches++;
            end else begin
                want = predicted_out.pop_front();
                results_checked++;
                if (b !== want.out_byte) begin
                    $error("out_byte mismatch: expected %h actual %h", want.out_byte, b);
                    mismatches++;
                end
                if (v !== want.verdict) begin
                    $error("verdict mismatch: expected %0d actual %0d", want.verdict, v);
                    mismatches++;
                end
                if (e !== want.frame_end) begin
                    $error("frame_end mismatch: expected %b actual %b", want.frame_end, e);
                    mismatches++;
                end
            end
        endfunction

    endclass

endpackage

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// crc16 frame unit testbench
// Drives byte frames in generate and check mode through the input stream with
// bursty timing, stalls the result stream on changing patterns (one long
// hold-off to fill the unit), steps the expected length register through
// several values and checks every result transfer against the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;

    import crc16fgc_pkg::*;
    import crc_frame_tb_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 140;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned HOLD_CYCLES  = 120;
    localparam int unsigned LIMIT_CYCLES = 600000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_wen = 1'b0;
    logic [LEN_W-1:0] i_cfg_wdata = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic [0:0]       s_axis_tuser = 1'b0;    // [0] func
    logic             s_axis_tlast = 1'b0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [7:0]       m_axis_tdata;           // [7:0] out_byte
    logic [1:0]       m_axis_tuser;           // [1:0] verdict
    logic             m_axis_tlast;

    crc_frame_scoreboard sb = new();

    int unsigned      items_sent = 0;
    int unsigned      burst_left = 0;
    int unsigned      cycle_count = 0;
    logic [LEN_W-1:0] cur_len = EXP_LEN_RESET;
    logic             hold_req = 1'b0;
    logic             hold_done = 1'b0;

    crc16_frame_generate_check_unit #(
        .MAX_FRAME (FRAME_LIMIT)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata, t_verdict'(m_axis_tuser), m_axis_tlast);
        end
    end

    // receiver: segments of always-ready, random and periodic stalls, one long hold
    initial begin
        int unsigned seg_len;
        int unsigned pattern;
        int unsigned period;
        int unsigned on_cnt;
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    m_axis_tready <= 1'b0;
                end
            end else begin
                pattern = $urandom_range(0, 2);
                seg_len = $urandom_range(8, 64);
                period  = $urandom_range(2, 9);
                on_cnt  = $urandom_range(1, period - 1);
                for (int k = 0; k < seg_len; k++) begin
                    // a requested hold starts right away
                    if (hold_req && !hold_done) begin
                        break;
                    end
                    @(negedge i_clk);
                    case (pattern)
                        0: begin
                            m_axis_tready <= 1'b1;
                        end
                        1: begin
                            m_axis_tready <= 1'($urandom_range(0, 1));
                        end
                        default: begin
                            m_axis_tready <= ((k % period) < on_cnt);
                        end
                    endcase
                end
            end
        end
    end

    // one input transfer, bursts separated by random gaps; starts and ends at negedge
    task automatic send_byte(logic func, logic [7:0] b, logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? 64 : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= func;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1) @(posedge i_clk);
        sb.note_byte(func, b, last);
        items_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    // mode goes on the first byte, later bytes carry random mode bits
    task automatic send_frame(logic func, logic [7:0] fb [$]);
        for (int k = 0; k < fb.size(); k++) begin
            send_byte((k == 0) ? func : 1'($urandom_range(0, 1)), fb[k], k == fb.size() - 1);
        end
    endtask

    task automatic send_gen_frame(int unsigned len);
        logic [7:0] fb [$];
        repeat (len) fb.push_back(8'($urandom_range(0, 255)));
        send_frame(1'b0, fb);
    endtask

    // check frame with its crc trailer (frames of two bytes or more), optionally one bit flipped
    task automatic send_check_frame(int unsigned len, logic corrupt);
        logic [7:0]  fb [$];
        logic [15:0] fcs;
        int unsigned pos;
        fcs = CRC_INIT;
        for (int k = 0; k + 2 < len; k++) begin
            fb.push_back(8'($urandom_range(0, 255)));
            fcs = crc_frame_scoreboard::fold_byte(fcs, fb[k]);
        end
        fcs = ~fcs;
        if (len >= 2) begin
            fb.push_back(fcs[7:0]);
            fb.push_back(fcs[15:8]);
        end else begin
            fb.push_back(8'($urandom_range(0, 255)));
        end
        if (corrupt) begin
            pos = $urandom_range(0, fb.size() - 1);
            fb[pos] = fb[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
        send_frame(1'b1, fb);
    endtask

    // drop valid, wait for all results, then let the pipeline drain
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_length(logic [LEN_W-1:0] len);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= len;
        @(negedge i_clk);
        i_cfg_wen   <= 1'b0;
        sb.exp_len = len;
        cur_len    = len;
    endtask

    // main sequence
    initial begin
        int unsigned directed_items;
        int unsigned pick;
        int unsigned nframes;
        int unsigned len;
        logic [7:0]  noise [$];

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: byte extremes, mode change inside a frame, reset length
        send_byte(1'b0, 8'h00, 1'b1);
        send_byte(1'b0, 8'hFF, 1'b0);
        send_byte(1'b1, 8'h5A, 1'b1);
        send_check_frame(EXP_LEN_RESET, 1'b0);
        send_byte(1'b1, 8'hFF, 1'b1);
        settle();
        // shortest length: two-byte frame must be 00 00
        write_length(11'd2);
        send_check_frame(2, 1'b0);
        send_check_frame(2, 1'b1);
        send_check_frame(3, 1'b0);
        settle();
        directed_items = items_sent;

        // long receiver hold while a long generate frame keeps coming
        hold_req = 1'b1;
        send_gen_frame(12);
        settle();

        // random phases
        while (items_sent < directed_items + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0: write_length(11'd2);
                1: write_length(11'd3);
                2: write_length(EXP_LEN_RESET);
                default: write_length(11'($urandom_range(4, 16)));
            endcase
            nframes = $urandom_range(3, 8);
            repeat (nframes) begin
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    send_gen_frame(($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 12));
                end else if (pick < 75) begin
                    send_check_frame(cur_len, $urandom_range(0, 3) == 0);
                end else if (pick < 90) begin
                    len = $urandom_range(1, cur_len + 3);
                    if (len == cur_len) begin
                        len++;
                    end
                    send_check_frame(len, 1'b0);
                end else begin
                    // noise: random bytes, random mode
                    noise.delete();
                    len = $urandom_range(1, cur_len + 2);
                    repeat (len) noise.push_back(8'($urandom_range(0, 255)));
                    send_frame(1'($urandom_range(0, 1)), noise);
                end
            end
            settle();
        end

        // largest frame length
        write_length(11'(FRAME_LIMIT));
        send_check_frame(FRAME_LIMIT, 1'b0);
        send_gen_frame(5);
        settle();
        // counter must saturate: 32 + 9 bytes may not wrap to a good length
        write_length(EXP_LEN_RESET);
        send_check_frame(32 + EXP_LEN_RESET, 1'b0);
        send_check_frame(EXP_LEN_RESET, 1'b0);
        settle();

        $display("run covered %0d input bytes, %0d result transfers checked",
                 items_sent, sb.results_checked);
        $display("%0d generate frames, %0d check frames (ok %0d, crc err %0d, len err %0d)",
                 sb.gen_frames, sb.chk_frames, sb.verdict_hits[1], sb.verdict_hits[2],
                 sb.verdict_hits[3]);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/crc16fgc_pkg.sv
src/crc16fgc_front.sv
src/crc16fgc_queue.sv
src/crc16fgc_back.sv
src/crc16_frame_generate_check_unit.sv
tb/crc_frame_scoreboard.sv
tb/tb_top.sv
